/* src/apid_pkg.sv */
`default_nettype none
package apid_pkg;

  localparam int unsigned HistDepth  = 100;
  localparam int unsigned HistAw     = $clog2(HistDepth);
  localparam int unsigned Warmup     = 300;
  localparam int unsigned MinFill    = HistDepth / 2;
  localparam int unsigned FillW      = $clog2(HistDepth + 1);
  localparam int unsigned RunW       = $clog2(Warmup + 1);
  localparam int unsigned FullDrive  = 16000;
  localparam int unsigned IntegLimit = 32000;

  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_PD     = 2'd1,
    MODE_FORCED = 2'd2,
    MODE_PID    = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_EVAL, ST_SLOPE, ST_P, ST_D, ST_I, ST_SUM, ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic        [13:0] drive;
    logic signed [23:0] p_term;
    logic signed [23:0] i_term;
    logic signed [23:0] d_term;
    logic        [1:0]  mode;
  } out_item_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [14:0] deadband_limit;
    logic [14:0] mode_switch_limit;
    logic [14:0] stuck_error_limit;
    logic [15:0] stuck_change_limit;
    logic [13:0] pd_drive_cap;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic wr_ring;
    logic eval;
    logic slope;
    logic quot_est;
    logic quot_fix;
    logic p;
    logic d;
    logic i;
    logic sum;
  } cmd_t;

  typedef struct packed {
    logic hold;
  } status_t;

  localparam logic [2:0] RegProp = 3'd0, RegInteg = 3'd1, RegDeriv = 3'd2, RegDead = 3'd3,
                         RegMode = 3'd4, RegStuckE = 3'd5, RegStuckC = 3'd6, RegCap = 3'd7;

endpackage
`default_nettype wire

/* src/apid_ram.sv */
`default_nettype none
module apid_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 100
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* src/apid_ctrl.sv */
`default_nettype none
module apid_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire apid_pkg::status_t status_i,
  output apid_pkg::cmd_t         cmd_o
);
  import apid_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // sequence one item through the shared datapath
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.wr_ring = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = status_i.hold ? ST_OUT : ST_SLOPE;
      end
      ST_SLOPE: begin cmd_o.slope = 1'b1; state_d = ST_P; end
      ST_P: begin
        cmd_o.p        = 1'b1;
        cmd_o.quot_est = 1'b1;
        state_d = ST_I;
      end
      ST_I: begin
        cmd_o.i        = 1'b1;
        cmd_o.quot_fix = 1'b1;
        state_d = ST_D;
      end
      ST_D:     begin cmd_o.d = 1'b1; state_d = ST_SUM; end
      ST_SUM:   begin cmd_o.sum = 1'b1; state_d = ST_OUT; end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* src/apid_dp.sv */
`default_nettype none
module apid_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire apid_pkg::cfg_t      cfg_i,
  input  wire apid_pkg::in_item_t  in_i,
  input  wire apid_pkg::cmd_t      cmd_i,
  output apid_pkg::status_t        status_o,
  output apid_pkg::out_item_t      out_o
);
  import apid_pkg::*;

  localparam logic signed [31:0] TermMax = 32'sd8388607;
  localparam logic signed [31:0] TermMin = -32'sd8388608;
  // rounding term plus ten times 2^32, which keeps the dividend positive
  localparam logic signed [38:0] SlopeBias = 39'sd42949672965;

  logic signed [15:0] smp_q, prev_q;
  logic signed [16:0] err_q;
  logic        [16:0] aerr;
  logic [HistAw-1:0]  wp_q, rd_addr;
  logic [FillW-1:0]   fill_q;
  logic [RunW-1:0]    run_q;
  logic               run_ok_q, forced_q, pd_q;
  logic [15:0]        old_raw;
  logic signed [31:0] slope_q;
  logic [35:0]        u_q, q_q;
  logic signed [20:0] integ_q;
  logic [13:0]        last_q;
  logic signed [23:0] p_q, i_q, d_q;
  logic [13:0]        drive_q;
  logic [1:0]         mode_q;
  logic signed [23:0] iv;
  logic [13:0]        cap, sum_drive;
  logic signed [26:0] tot;

  assign aerr = err_q[16] ? 17'(-err_q) : 17'(err_q);

  // oldest entry of the window, after the new sample is counted
  always_comb begin
    logic [8:0] a;
    a = 9'(wp_q) + 9'(HistDepth + 1) - 9'(fill_q);
    if (a >= 9'(HistDepth)) a = a - 9'(HistDepth);
    rd_addr = a[HistAw-1:0];
  end

  apid_ram #(.Width(16), .Depth(HistDepth)) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_ring),
    .waddr_i(wp_q),
    .wdata_i(smp_q),
    .raddr_i(rd_addr),
    .rdata_o(old_raw)
  );

  // saturate to 24 bits
  function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
    if (x > 64'(TermMax)) return TermMax[23:0];
    if (x < 64'(TermMin)) return TermMin[23:0];
    return x[23:0];
  endfunction

  assign status_o.hold = aerr < 17'(cfg_i.deadband_limit);

  // integral term and clamped drive from the registered terms
  always_comb begin
    iv = pd_q ? 24'sd0
         : sat24((64'($signed({1'b0, cfg_i.integ_gain})) * 64'(integ_q) + 64'sd256) >>> 9);
    cap = pd_q ? ((cfg_i.pd_drive_cap > 14'(FullDrive)) ? 14'(FullDrive)
                                                         : cfg_i.pd_drive_cap)
               : 14'(FullDrive);
    tot = 27'(p_q) + 27'(iv) + 27'(d_q);
    if (tot < 0) sum_drive = '0;
    else if (tot > 27'($signed({1'b0, cap}))) sum_drive = cap;
    else sum_drive = tot[13:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; fill_q <= '0; run_q <= '0; prev_q <= '0; slope_q <= '0;
      integ_q <= '0; last_q <= '0; run_ok_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        run_ok_q <= run_q >= RunW'(Warmup);
        if (run_q < RunW'(Warmup)) run_q <= run_q + 1'b1;
        if (fill_q < FillW'(HistDepth)) fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.wr_ring)
        wp_q <= (wp_q == HistAw'(HistDepth - 1)) ? '0 : wp_q + 1'b1;
      if (cmd_i.slope) prev_q <= smp_q;
      // finish the divide by ten: one or two steps of correction
      if (cmd_i.quot_fix) begin
        logic [35:0] t;
        logic [35:0] r;
        t = q_q + (q_q >> 32);
        t = t >> 3;
        r = u_q - ((t << 3) + (t << 1));
        if (r >= 36'd20) t = t + 36'd2;
        else if (r >= 36'd10) t = t + 36'd1;
        slope_q <= t[31:0];
      end
      if (cmd_i.i && !pd_q) begin
        logic signed [21:0] s;
        s = 22'(integ_q) + (forced_q ? 22'(err_q) : 22'(err_q) <<< 1);
        if (s > 22'sd32000) integ_q <= 21'sd32000;
        else if (s < -22'sd32000) integ_q <= -21'sd32000;
        else integ_q <= s[20:0];
      end
      if (cmd_i.sum) last_q <= sum_drive;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q <= in_i.sample;
      err_q <= 17'(in_i.setpoint) - 17'(in_i.sample);
    end
    if (cmd_i.eval) begin
      logic [16:0] chg;
      logic signed [16:0] df;
      logic f;
      df = 17'(smp_q) - 17'($signed(old_raw));
      chg = (fill_q >= FillW'(2)) ? (df[16] ? 17'(-df) : 17'(df)) : '0;
      f = aerr > 17'(cfg_i.stuck_error_limit) && chg < 17'(cfg_i.stuck_change_limit) &&
          fill_q >= FillW'(MinFill) && run_ok_q;
      forced_q <= f;
      pd_q <= aerr > 17'(cfg_i.mode_switch_limit) && !f;
      p_q <= '0; i_q <= '0; d_q <= '0;
      drive_q <= last_q;
      mode_q <= MODE_HOLD;
    end
    // biased filter numerator, always positive
    if (cmd_i.slope) begin
      logic signed [38:0] num;
      num = 39'(slope_q) * 39'sd6 + ((39'(prev_q) - 39'(smp_q)) <<< 10) + SlopeBias;
      u_q <= num[35:0];
    end
    // estimate the quotient by ten with shift and add
    if (cmd_i.quot_est) begin
      logic [35:0] t;
      t = (u_q >> 1) + (u_q >> 2);
      t = t + (t >> 4);
      t = t + (t >> 8);
      t = t + (t >> 16);
      q_q <= t;
    end
    if (cmd_i.p)
      p_q <= sat24((64'($signed({1'b0, cfg_i.prop_gain})) * 64'(err_q) + 64'sd128) >>> 8);
    if (cmd_i.d)
      d_q <= sat24((64'($signed({1'b0, cfg_i.deriv_gain})) * 64'(slope_q) + 64'sd32768)
                   >>> 16);
    if (cmd_i.i) begin
      if (pd_q) begin
        i_q <= '0;
        mode_q <= MODE_PD;
      end else begin
        mode_q <= forced_q ? MODE_FORCED : MODE_PID;
      end
    end
    if (cmd_i.sum) begin
      i_q <= iv;
      drive_q <= sum_drive;
    end
  end

  // present the result registers
  assign out_o.drive  = drive_q;
  assign out_o.p_term = p_q;
  assign out_o.i_term = i_q;
  assign out_o.d_term = d_q;
  assign out_o.mode   = mode_q;
endmodule
`default_nettype wire

/* src/adaptive_pid_temperature_controller_core.sv */
`default_nettype none
// channel | direction | handshake        | payload
// in      | input     | in_valid_i/stall | in_item_t  (setpoint, sample)
// out     | output    | out_valid_o/stall| out_item_t (drive, terms, mode)
// cfg     | input     | APB write/read   | eight registers at 4*i
// An item walks the sequencer through the history RAM read, slope, P with the
// divide estimate, I with the divide correction, D and sum steps; in deadband
// hold it skips from the evaluate step straight to the output.
// Reset clears the sequencer, configuration, history and integral state only.
// A stalled result holds in place; no new item enters until it is taken.
module adaptive_pid_temperature_controller_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire apid_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output apid_pkg::out_item_t      out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import apid_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{prop_gain: 16'd256, integ_gain: 16'd0, deriv_gain: 16'd0,
                 deadband_limit: 15'd8, mode_switch_limit: 15'd160,
                 stuck_error_limit: 15'd80, stuck_change_limit: 16'd80,
                 pd_drive_cap: 14'd12000};
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        RegProp:   cfg_q.prop_gain          <= pwdata[15:0];
        RegInteg:  cfg_q.integ_gain         <= pwdata[15:0];
        RegDeriv:  cfg_q.deriv_gain         <= pwdata[15:0];
        RegDead:   cfg_q.deadband_limit     <= pwdata[14:0];
        RegMode:   cfg_q.mode_switch_limit  <= pwdata[14:0];
        RegStuckE: cfg_q.stuck_error_limit  <= pwdata[14:0];
        RegStuckC: cfg_q.stuck_change_limit <= pwdata[15:0];
        RegCap:    cfg_q.pd_drive_cap       <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (ridx)
      RegProp:   prdata = {16'd0, cfg_q.prop_gain};
      RegInteg:  prdata = {16'd0, cfg_q.integ_gain};
      RegDeriv:  prdata = {16'd0, cfg_q.deriv_gain};
      RegDead:   prdata = {17'd0, cfg_q.deadband_limit};
      RegMode:   prdata = {17'd0, cfg_q.mode_switch_limit};
      RegStuckE: prdata = {17'd0, cfg_q.stuck_error_limit};
      RegStuckC: prdata = {16'd0, cfg_q.stuck_change_limit};
      RegCap:    prdata = {18'd0, cfg_q.pd_drive_cap};
      default:   prdata = '0;
    endcase
  end

  apid_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .status_i(status), .cmd_o(cmd)
  );

  apid_dp u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_i(in_data_i), .cmd_i(cmd),
    .status_o(status), .out_o(out_data_o)
  );
endmodule
`default_nettype wire

/* tb/adaptive_pid_temperature_controller_core_test.sv */
`timescale 1ns / 1ps

module adaptive_pid_temperature_controller_core_test;
  import apid_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  adaptive_pid_temperature_controller_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Controller copy: configuration
  logic [15:0] kp, ki, kd, stuck_chg;
  logic [14:0] dead_lim, switch_lim, stuck_err;
  logic [13:0] cap_pd;

  // Controller copy: state
  logic signed [15:0] temp_hist [HistDepth];
  int unsigned hist_wp, hist_fill, warm_count;
  longint      last_temp, slope_acc, integ_acc, held_drive;

  in_item_t    sample_queue[$];
  out_item_t   drive_queue[$];
  int unsigned mismatches, cycles, items_sent, results_seen;
  int unsigned in_gap, out_wait;
  logic        in_quiet, out_quiet;
  int unsigned mode_seen [4];
  logic signed [15:0] base_temp;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sat(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // Compute the drive and terms for one item and advance the controller copy
  function automatic out_item_t control_step(in_item_t it);
    longint sp, smp, err, aerr, change, p, i, d, cap, drv, num, q, oldest, newest;
    logic forced;
    mode_e md;
    out_item_t r;
    sp = longint'($signed(it.setpoint));
    smp = longint'($signed(it.sample));
    err = sp - smp;
    aerr = err < 0 ? -err : err;
    change = 0; p = 0; i = 0; d = 0; cap = FullDrive;
    temp_hist[hist_wp] = it.sample;
    hist_wp = (hist_wp + 1) % HistDepth;
    if (hist_fill < HistDepth) hist_fill++;
    if (hist_fill >= 2) begin
      oldest = longint'(temp_hist[(hist_wp + HistDepth - hist_fill) % HistDepth]);
      newest = longint'(temp_hist[(hist_wp + HistDepth - 1) % HistDepth]);
      change = newest >= oldest ? newest - oldest : oldest - newest;
    end
    forced = aerr > longint'(stuck_err) && change < longint'(stuck_chg) &&
             hist_fill >= MinFill && warm_count >= Warmup;
    if (warm_count < Warmup) warm_count++;
    if (aerr < longint'(dead_lim)) begin
      drv = held_drive;
      md = MODE_HOLD;
    end else begin
      num = 6 * slope_acc + 1024 * (last_temp - smp) + 5;
      q = num / 10;
      if (num % 10 != 0 && num < 0) q--;
      slope_acc = sat(q, -64'sd2147483648, 64'sd2147483647);
      p = sat((longint'(kp) * err + 128) >>> 8, -8388608, 8388607);
      d = sat((longint'(kd) * slope_acc + 32768) >>> 16, -8388608, 8388607);
      if (aerr > longint'(switch_lim) && !forced) begin
        md = MODE_PD;
        cap = cap_pd > FullDrive ? FullDrive : longint'(cap_pd);
      end else begin
        md = forced ? MODE_FORCED : MODE_PID;
        integ_acc = sat(integ_acc + (forced ? err : 2 * err), -longint'(IntegLimit),
                        longint'(IntegLimit));
        i = sat((longint'(ki) * integ_acc + 256) >>> 9, -8388608, 8388607);
      end
      drv = sat(p + i + d, 0, cap);
      last_temp = smp;
      held_drive = drv;
    end
    r.drive = drv[13:0];
    r.p_term = p[23:0];
    r.i_term = i[23:0];
    r.d_term = d[23:0];
    r.mode = md;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, field, got, want);
    mismatches++;
  endtask

  // Driver: present queued items, hold while stalled, idle for a random gap between items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      in_gap = 0;
      in_quiet = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        drive_queue.push_back(control_step(in_data_i));
        items_sent++;
        if ($urandom_range(0, 39) == 0) in_quiet = ~in_quiet;
        in_gap = in_quiet ? 0 : $urandom_range(0, 9);
        if (in_gap == 0 && sample_queue.size() != 0) begin
          in_data_i <= sample_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (sample_queue.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= sample_queue.pop_front();
        end
      end
    end
  end

  // Monitor: check each taken result, then stall for a random count
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_wait = 0;
      out_quiet = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (drive_queue.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          out_item_t want;
          want = drive_queue.pop_front();
          if (out_data_o.drive !== want.drive)
            report("drive", out_data_o.drive, want.drive);
          if (out_data_o.p_term !== want.p_term)
            report("p_term", out_data_o.p_term, want.p_term);
          if (out_data_o.i_term !== want.i_term)
            report("i_term", out_data_o.i_term, want.i_term);
          if (out_data_o.d_term !== want.d_term)
            report("d_term", out_data_o.d_term, want.d_term);
          if (out_data_o.mode !== want.mode)
            report("mode", out_data_o.mode, want.mode);
          mode_seen[want.mode]++;
        end
        results_seen++;
        if ($urandom_range(0, 39) == 0) out_quiet = ~out_quiet;
        out_wait = out_quiet ? 0 : $urandom_range(0, 9);
      end
      if (out_wait != 0) begin
        out_stall_i <= 1'b1;
        out_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegProp:   kp = value[15:0];
      RegInteg:  ki = value[15:0];
      RegDeriv:  kd = value[15:0];
      RegDead:   dead_lim = value[14:0];
      RegMode:   switch_lim = value[14:0];
      RegStuckE: stuck_err = value[14:0];
      RegStuckC: stuck_chg = value[15:0];
      default:   cap_pd = value[13:0];
    endcase
  endtask

  task automatic set_gains(logic [15:0] p, logic [15:0] i, logic [15:0] d, logic [14:0] db,
                           logic [14:0] sw, logic [14:0] se, logic [15:0] sc,
                           logic [13:0] cap);
    reg_write(RegProp, 32'(p));
    reg_write(RegInteg, 32'(i));
    reg_write(RegDeriv, 32'(d));
    reg_write(RegDead, 32'(db));
    reg_write(RegMode, 32'(sw));
    reg_write(RegStuckE, 32'(se));
    reg_write(RegStuckC, 32'(sc));
    reg_write(RegCap, 32'(cap));
  endtask

  // Wait until every queued item has come back, then let the block settle
  task automatic drain();
    while (sample_queue.size() != 0 || in_valid_i || drive_queue.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(logic signed [15:0] sp, logic signed [15:0] smp);
    in_item_t it;
    it.setpoint = sp;
    it.sample = smp;
    return it;
  endfunction

  // Mostly plausible plant behavior: stuck heater, tracking, steps, then noise
  function automatic in_item_t random_item();
    int unsigned pick;
    logic signed [15:0] s;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 59) == 0) base_temp = 16'(int'($urandom_range(0, 8000)) - 2000);
    if (pick < 40) begin
      s = 16'(int'(base_temp) + int'($urandom_range(0, 8)) - 4);
      return make_item(16'(int'(base_temp) + int'($urandom_range(60, 600)) *
                           (($urandom_range(0, 1) != 0) ? 1 : -1)), s);
    end else if (pick < 65) begin
      s = 16'(int'(base_temp) + int'($urandom_range(0, 200)) - 100);
      return make_item(16'(int'(s) + int'($urandom_range(0, 40)) - 20), s);
    end else if (pick < 85) begin
      s = 16'(int'(base_temp) + int'($urandom_range(0, 2000)) - 1000);
      return make_item(16'(int'(base_temp) + int'($urandom_range(0, 3000)) - 1500), s);
    end
    return make_item(16'($urandom()), 16'($urandom()));
  endfunction

  task automatic queue_random(int unsigned count);
    repeat (count) sample_queue.push_back(random_item());
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    kp = 16'd256; ki = 16'd0; kd = 16'd0; dead_lim = 15'd8; switch_lim = 15'd160;
    stuck_err = 15'd80; stuck_chg = 16'd80; cap_pd = 14'd12000;
    hist_wp = 0; hist_fill = 0; warm_count = 0;
    last_temp = 0; slope_acc = 0; integ_acc = 0; held_drive = 0;
    mismatches = 0; cycles = 0; items_sent = 0; results_seen = 0;
    base_temp = 16'sd1600;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, hold, P+D, normal PID under reset gains
    sample_queue.push_back(make_item(16'sd0, 16'sd0));
    sample_queue.push_back(make_item(16'sd3, 16'sd0));
    sample_queue.push_back(make_item(16'sd100, 16'sd0));
    sample_queue.push_back(make_item(16'sd2000, 16'sd0));
    sample_queue.push_back(make_item(16'sh7fff, 16'sh8000));
    sample_queue.push_back(make_item(16'sh8000, 16'sh7fff));
    sample_queue.push_back(make_item(16'sh7fff, 16'sh7fff));
    sample_queue.push_back(make_item(16'sh8000, 16'sh8000));
    sample_queue.push_back(make_item(16'sh8000, 16'sd0));
    sample_queue.push_back(make_item(16'sd1600, 16'sd1592));
    sample_queue.push_back(make_item(16'sd1600, 16'sd1440));
    sample_queue.push_back(make_item(16'sd1600, 16'sd1439));
    drain();

    set_gains(16'd512, 16'd200, 16'd3000, 15'd4, 15'd300, 15'd40, 16'd30, 14'd9000);
    sample_queue.push_back(make_item(16'sd1000, 16'sd0));
    sample_queue.push_back(make_item(16'sd1000, 16'sd1500));
    sample_queue.push_back(make_item(16'sd1000, 16'sd996));
    sample_queue.push_back(make_item(16'sd1000, 16'sd1000));
    sample_queue.push_back(make_item(16'sd1000, 16'sd800));
    queue_random(300);
    drain();

    // Extremes of every register
    set_gains(16'hffff, 16'hffff, 16'hffff, 15'd0, 15'd0, 15'd0, 16'hffff, 14'd16000);
    queue_random(180);
    drain();
    set_gains(16'd0, 16'd0, 16'd0, 15'h7fff, 15'h7fff, 15'h7fff, 16'd0, 14'd0);
    queue_random(60);
    drain();
    set_gains(16'd300, 16'hffff, 16'd20000, 15'd2, 15'h7fff, 15'd50, 16'd200, 14'h3fff);
    queue_random(250);
    drain();

    // Random settings around the useful range
    repeat (3) begin
      set_gains(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 4096)),
                16'($urandom_range(0, 65535)), 15'($urandom_range(0, 30)),
                15'($urandom_range(100, 800)), 15'($urandom_range(20, 300)),
                16'($urandom_range(10, 400)), 14'($urandom_range(0, 16383)));
      queue_random(180);
      drain();
    end

    $display("%0d items checked over eight register settings", items_sent);
    $display("modes seen: hold %0d, P+D %0d, forced %0d, PID %0d",
             mode_seen[MODE_HOLD], mode_seen[MODE_PD], mode_seen[MODE_FORCED],
             mode_seen[MODE_PID]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
